// File: rtl/psws_pkg.sv
`default_nettype none
package psws_pkg;

  localparam int NUM_SLOTS       = 16;
  localparam int PRIORITY_LEVELS = 64;

  localparam int SLOT_W  = $clog2(NUM_SLOTS);
  localparam int CUR_W   = $clog2(NUM_SLOTS + 1);
  localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
  localparam int KIND_W  = 3;
  localparam int TSLOT_W = 4;
  localparam int PRIO_W  = 6;
  localparam int TICK_W  = 32;
  localparam int STAMP_W = 32;
  localparam int SLICE_W = 8;

  localparam logic [CUR_W-1:0]   IDLE_SLOT     = CUR_W'(NUM_SLOTS);
  localparam logic [SLICE_W-1:0] SLICE_RESET   = 8'd4;
  localparam logic [PRIO_W-1:0]  PRIO_MAX      = PRIO_W'(PRIORITY_LEVELS - 1);

  typedef enum logic [KIND_W-1:0] {
    K_TICK    = 3'd0,
    K_CREATE  = 3'd1,
    K_UNBLOCK = 3'd2,
    K_SLEEP   = 3'd3,
    K_YIELD   = 3'd4,
    K_BLOCK   = 3'd5,
    K_SETPRIO = 3'd6,
    K_EXIT    = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_FREE     = 3'd0,
    ST_BLOCKED  = 3'd1,
    ST_READY    = 3'd2,
    ST_RUNNING  = 3'd3,
    ST_SLEEPING = 3'd4
  } slot_state_t;

  typedef enum logic {
    SM_READY = 1'b0,
    SM_WAKE  = 1'b1
  } scan_mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_WAKE_CHK,
    S_YIELD_PUT,
    S_RESCHED_CHK,
    S_PROBE_CHK,
    S_PREEMPT_CHK,
    S_OTHER,
    S_COUNT,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic              en;
    logic [CUR_W-1:0]  idx;
    logic              set_state;
    slot_state_t       state;
    logic              set_prio;
    logic [PRIO_W-1:0] prio;
    logic              set_wake;
    logic [TICK_W-1:0] wake;
    logic              set_stamp;
    logic [STAMP_W-1:0] stamp;
  } wr_cmd_t;

  typedef struct packed {
    scan_mode_t        mode;
    logic [TICK_W-1:0] now;
    logic [CUR_W-1:0]  probe;
  } scan_cmd_t;

  typedef struct packed {
    logic               found;
    logic [CUR_W-1:0]   idx;
    logic [PRIO_W-1:0]  prio;
    logic [TICK_W-1:0]  wake;
    logic [STAMP_W-1:0] stamp;
    logic [CNT_W-1:0]   count;
    slot_state_t        probe_state;
    logic [PRIO_W-1:0]  probe_prio;
  } cand_t;

endpackage
`default_nettype wire

// File: rtl/psws_cell.sv
`default_nettype none
module psws_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [psws_pkg::CUR_W-1:0]  own_idx,
  input  wire psws_pkg::wr_cmd_t           wr,
  input  wire psws_pkg::scan_cmd_t         scan,
  input  wire psws_pkg::cand_t             cand_in,
  output psws_pkg::cand_t                  cand_out
);

  psws_pkg::slot_state_t               state;
  logic [psws_pkg::PRIO_W-1:0]         prio;
  logic [psws_pkg::TICK_W-1:0]         wake;
  logic [psws_pkg::STAMP_W-1:0]        stamp;

  logic           hit;
  logic           elig;
  logic           better;
  psws_pkg::cand_t nxt;

  assign hit = wr.en && (wr.idx == own_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psws_pkg::ST_FREE;
    end else if (hit && wr.set_state) begin
      state <= wr.state;
    end
  end

  always_ff @(posedge clk) begin
    if (hit && wr.set_prio) begin
      prio <= wr.prio;
    end
    if (hit && wr.set_wake) begin
      wake <= wr.wake;
    end
    if (hit && wr.set_stamp) begin
      stamp <= wr.stamp;
    end
  end

  always_comb begin
    if (scan.mode == psws_pkg::SM_READY) begin
      elig   = (state == psws_pkg::ST_READY);
      better = !cand_in.found || (prio > cand_in.prio) ||
               ((prio == cand_in.prio) && (stamp < cand_in.stamp));
    end else begin
      elig   = (state == psws_pkg::ST_SLEEPING) && (wake <= scan.now);
      better = !cand_in.found || (wake < cand_in.wake) ||
               ((wake == cand_in.wake) && (stamp < cand_in.stamp));
    end
  end

  always_comb begin
    nxt = cand_in;
    if (elig && better) begin
      nxt.found = 1'b1;
      nxt.idx   = own_idx;
      nxt.prio  = prio;
      nxt.wake  = wake;
      nxt.stamp = stamp;
    end
    if (state == psws_pkg::ST_READY) begin
      nxt.count = cand_in.count + psws_pkg::CNT_W'(1);
    end
    if (scan.probe == own_idx) begin
      nxt.probe_state = state;
      nxt.probe_prio  = prio;
    end
  end

  // The candidate advances one cell per clock.
  always_ff @(posedge clk) begin
    cand_out <= nxt;
  end

endmodule
`default_nettype wire

// File: rtl/psws_chain.sv
`default_nettype none
module psws_chain (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire psws_pkg::wr_cmd_t   wr,
  input  wire psws_pkg::scan_cmd_t scan,
  output psws_pkg::cand_t          tail
);

  psws_pkg::cand_t link [psws_pkg::NUM_SLOTS+1];

  always_comb begin
    link[0]             = '0;
    link[0].probe_state = psws_pkg::ST_FREE;
  end

  for (genvar i = 0; i < psws_pkg::NUM_SLOTS; i++) begin : g_cell
    psws_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .own_idx  (psws_pkg::CUR_W'(i)),
      .wr       (wr),
      .scan     (scan),
      .cand_in  (link[i]),
      .cand_out (link[i+1])
    );
  end

  assign tail = link[psws_pkg::NUM_SLOTS];

endmodule
`default_nettype wire

// File: rtl/psws_ctrl.sv
`default_nettype none
module psws_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic [psws_pkg::SLICE_W-1:0]  cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [psws_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [psws_pkg::TSLOT_W-1:0]  in_slot,
  input  wire logic [psws_pkg::PRIO_W-1:0]   in_prio,
  input  wire logic [psws_pkg::TICK_W-1:0]   in_tick,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [psws_pkg::CUR_W-1:0]         out_running,
  output logic                               out_switched,
  output logic [psws_pkg::CNT_W-1:0]         out_woken,
  output logic [psws_pkg::CNT_W-1:0]         out_ready_cnt,
  output logic                               out_status,
  input  wire psws_pkg::cand_t               tail,
  output psws_pkg::wr_cmd_t                  wr,
  output psws_pkg::scan_cmd_t                scan
);

  psws_pkg::fsm_t  state, state_next, scan_ret, ret_next;
  psws_pkg::kind_t kind;
  logic [psws_pkg::TSLOT_W-1:0] slot;
  logic [psws_pkg::PRIO_W-1:0]  prio;
  logic [psws_pkg::TICK_W-1:0]  tick;
  logic [psws_pkg::CUR_W-1:0]   cur;
  logic [psws_pkg::SLICE_W-1:0] slice;
  logic [psws_pkg::SLICE_W-1:0] slice_len;
  logic [psws_pkg::STAMP_W-1:0] order_ctr;
  logic [psws_pkg::CNT_W-1:0]   woken;
  logic [psws_pkg::CNT_W-1:0]   ready_cnt;
  logic                         sw;
  logic                         st;
  logic [psws_pkg::SLOT_W-1:0]  cnt;

  logic                         scan_go;
  psws_pkg::scan_cmd_t          scan_next;
  logic                         cur_valid;
  logic                         slot_ok;
  logic                         probe_bad;
  logic                         preempt;
  logic [psws_pkg::SLICE_W-1:0] slice_inc;
  logic                         slice_hit;
  logic                         out_free;
  logic [psws_pkg::PRIO_W-1:0]  prio_sat;

  assign in_ready  = (state == psws_pkg::S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign cur_valid = (cur < psws_pkg::IDLE_SLOT);
  assign slot_ok   = (int'(slot) < psws_pkg::NUM_SLOTS);
  assign slice_inc = (slice == '1) ? slice : slice + psws_pkg::SLICE_W'(1);
  assign slice_hit = (slice_inc >= slice_len);
  assign preempt   = tail.found && cur_valid && (tail.probe_prio < tail.prio);
  assign prio_sat  = (int'(in_prio) >= psws_pkg::PRIORITY_LEVELS) ? psws_pkg::PRIO_MAX
                                                                    : in_prio;

  always_comb begin
    if (kind == psws_pkg::K_CREATE) begin
      probe_bad = !slot_ok || (tail.probe_state != psws_pkg::ST_FREE);
    end else begin
      probe_bad = !slot_ok || (tail.probe_state != psws_pkg::ST_BLOCKED);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      psws_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = psws_pkg::S_DISPATCH;
        end
      end
      psws_pkg::S_DISPATCH: begin
        case (kind)
          psws_pkg::K_TICK, psws_pkg::K_CREATE, psws_pkg::K_UNBLOCK:
            state_next = psws_pkg::S_SCAN;
          psws_pkg::K_YIELD:
            state_next = psws_pkg::S_YIELD_PUT;
          default:
            state_next = cur_valid ? psws_pkg::S_OTHER : psws_pkg::S_SCAN;
        endcase
      end
      psws_pkg::S_SCAN: begin
        if (cnt == psws_pkg::SLOT_W'(psws_pkg::NUM_SLOTS - 1)) begin
          state_next = scan_ret;
        end
      end
      psws_pkg::S_WAKE_CHK: begin
        if (!tail.found && slice_hit) begin
          state_next = psws_pkg::S_YIELD_PUT;
        end else begin
          state_next = psws_pkg::S_SCAN;
        end
      end
      psws_pkg::S_PREEMPT_CHK: begin
        state_next = preempt ? psws_pkg::S_YIELD_PUT : psws_pkg::S_SCAN;
      end
      psws_pkg::S_YIELD_PUT, psws_pkg::S_RESCHED_CHK, psws_pkg::S_PROBE_CHK,
      psws_pkg::S_OTHER: begin
        state_next = psws_pkg::S_SCAN;
      end
      psws_pkg::S_COUNT: begin
        state_next = psws_pkg::S_DONE;
      end
      psws_pkg::S_DONE: begin
        if (out_free) begin
          state_next = psws_pkg::S_IDLE;
        end
      end
      default: state_next = psws_pkg::S_IDLE;
    endcase
  end

  // Slot writes and scan requests.
  always_comb begin
    wr             = '0;
    wr.idx         = cur;
    wr.state       = psws_pkg::ST_READY;
    wr.prio        = prio;
    wr.wake        = tick;
    wr.stamp       = order_ctr;
    scan_go        = 1'b0;
    scan_next.mode = psws_pkg::SM_READY;
    scan_next.now  = tick;
    scan_next.probe = cur;
    ret_next       = psws_pkg::S_COUNT;
    case (state)
      psws_pkg::S_DISPATCH: begin
        case (kind)
          psws_pkg::K_TICK: begin
            scan_go        = 1'b1;
            scan_next.mode = psws_pkg::SM_WAKE;
            ret_next       = psws_pkg::S_WAKE_CHK;
          end
          psws_pkg::K_CREATE, psws_pkg::K_UNBLOCK: begin
            scan_go         = 1'b1;
            scan_next.probe = psws_pkg::CUR_W'(slot);
            ret_next        = psws_pkg::S_PROBE_CHK;
          end
          psws_pkg::K_YIELD: ;
          default: scan_go = !cur_valid;
        endcase
      end
      psws_pkg::S_WAKE_CHK: begin
        if (tail.found) begin
          wr.en          = 1'b1;
          wr.idx         = tail.idx;
          wr.set_state   = 1'b1;
          wr.set_stamp   = 1'b1;
          scan_go        = 1'b1;
          scan_next.mode = psws_pkg::SM_WAKE;
          ret_next       = psws_pkg::S_WAKE_CHK;
        end else begin
          scan_go = !slice_hit;
        end
      end
      psws_pkg::S_YIELD_PUT: begin
        wr.en        = cur_valid;
        wr.set_state = 1'b1;
        wr.set_stamp = 1'b1;
        scan_go      = 1'b1;
        ret_next     = psws_pkg::S_RESCHED_CHK;
      end
      psws_pkg::S_RESCHED_CHK: begin
        wr.en        = tail.found;
        wr.idx       = tail.idx;
        wr.set_state = 1'b1;
        wr.state     = psws_pkg::ST_RUNNING;
        scan_go      = 1'b1;
      end
      psws_pkg::S_PROBE_CHK: begin
        scan_go = 1'b1;
        if (!probe_bad) begin
          wr.en        = 1'b1;
          wr.idx       = psws_pkg::CUR_W'(slot);
          wr.set_state = 1'b1;
          wr.set_stamp = 1'b1;
          if (kind == psws_pkg::K_CREATE) begin
            wr.set_prio = 1'b1;
            ret_next    = psws_pkg::S_PREEMPT_CHK;
          end
        end
      end
      psws_pkg::S_PREEMPT_CHK: begin
        scan_go = !preempt;
      end
      psws_pkg::S_OTHER: begin
        wr.en   = 1'b1;
        scan_go = 1'b1;
        case (kind)
          psws_pkg::K_SETPRIO: begin
            wr.set_prio = 1'b1;
            ret_next    = psws_pkg::S_PREEMPT_CHK;
          end
          psws_pkg::K_SLEEP: begin
            wr.set_state = 1'b1;
            wr.state     = psws_pkg::ST_SLEEPING;
            wr.set_wake  = 1'b1;
            wr.set_stamp = 1'b1;
            ret_next     = psws_pkg::S_RESCHED_CHK;
          end
          psws_pkg::K_BLOCK: begin
            wr.set_state = 1'b1;
            wr.state     = psws_pkg::ST_BLOCKED;
            ret_next     = psws_pkg::S_RESCHED_CHK;
          end
          default: begin
            wr.set_state = 1'b1;
            wr.state     = psws_pkg::ST_FREE;
            ret_next     = psws_pkg::S_RESCHED_CHK;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= psws_pkg::S_IDLE;
      scan_ret   <= psws_pkg::S_COUNT;
      cur        <= psws_pkg::IDLE_SLOT;
      slice      <= '0;
      slice_len  <= psws_pkg::SLICE_RESET;
      order_ctr  <= '0;
      out_valid  <= 1'b0;
      cnt        <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        slice_len <= cfg_data;
      end
      if (wr.en && wr.set_stamp) begin
        order_ctr <= order_ctr + psws_pkg::STAMP_W'(1);
      end
      if (scan_go) begin
        scan_ret <= ret_next;
        cnt      <= '0;
      end else if (state == psws_pkg::S_SCAN) begin
        cnt <= cnt + psws_pkg::SLOT_W'(1);
      end
      if (state == psws_pkg::S_WAKE_CHK && !tail.found) begin
        slice <= slice_inc;
      end
      if (state == psws_pkg::S_RESCHED_CHK) begin
        cur   <= tail.found ? tail.idx : psws_pkg::IDLE_SLOT;
        slice <= '0;
      end
      if (state == psws_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_go) begin
      scan <= scan_next;
    end
    case (state)
      psws_pkg::S_IDLE: begin
        kind  <= psws_pkg::kind_t'(in_kind);
        slot  <= in_slot;
        prio  <= prio_sat;
        tick  <= in_tick;
        woken <= '0;
        sw    <= 1'b0;
        st    <= 1'b0;
      end
      psws_pkg::S_DISPATCH: begin
        if (kind == psws_pkg::K_YIELD) begin
          sw <= 1'b1;
        end else if (kind != psws_pkg::K_TICK && kind != psws_pkg::K_CREATE &&
                     kind != psws_pkg::K_UNBLOCK && !cur_valid) begin
          st <= 1'b1;
        end
      end
      psws_pkg::S_WAKE_CHK: begin
        if (tail.found) begin
          woken <= woken + psws_pkg::CNT_W'(1);
        end else if (slice_hit) begin
          sw <= 1'b1;
        end
      end
      psws_pkg::S_PROBE_CHK: begin
        if (probe_bad) begin
          st <= 1'b1;
        end
      end
      psws_pkg::S_PREEMPT_CHK: begin
        if (preempt) begin
          sw <= 1'b1;
        end
      end
      psws_pkg::S_OTHER: begin
        if (kind != psws_pkg::K_SETPRIO) begin
          sw <= 1'b1;
        end
      end
      psws_pkg::S_COUNT: begin
        ready_cnt <= tail.count;
      end
      psws_pkg::S_DONE: begin
        if (out_free) begin
          out_running   <= cur;
          out_switched  <= sw;
          out_woken     <= woken;
          out_ready_cnt <= ready_cnt;
          out_status    <= st;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/priority_scheduler_with_sleep.sv
`default_nettype none
// Channel   Direction  Handshake           Content
// cfg       in         cfg_valid/ready     slice length write
// s_axis    in         s_tvalid/s_tready   one scheduler event
// m_axis    out        m_tvalid/m_tready   one result per event
//
// Every lookup is a wave that walks the row of slot cells, one cell per clock,
// and an event needs one to four scans plus one per slot woken.
// Reset is synchronous and frees all slots; no clearing pass is needed.
// A new event is taken only between events; a stalled result is held in the
// output register and the next event may be accepted while it waits.
module priority_scheduler_with_sleep (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // thread_slot, priority_req, tick_value, zero fill
  input  wire logic [2:0]  s_tuser,  // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata   // running_slot, switched, woken_count, ready_count,
                                     // status, zero fill
);

  psws_pkg::cand_t     tail;
  psws_pkg::wr_cmd_t   wr;
  psws_pkg::scan_cmd_t scan;

  logic [psws_pkg::CUR_W-1:0] running;
  logic                       switched;
  logic [psws_pkg::CNT_W-1:0] woken;
  logic [psws_pkg::CNT_W-1:0] ready_cnt;
  logic                       status;

  assign cfg_ready = 1'b1;

  psws_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_kind       (s_tuser),
    .in_slot       (s_tdata[3:0]),
    .in_prio       (s_tdata[9:4]),
    .in_tick       (s_tdata[41:10]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_running   (running),
    .out_switched  (switched),
    .out_woken     (woken),
    .out_ready_cnt (ready_cnt),
    .out_status    (status),
    .tail          (tail),
    .wr            (wr),
    .scan          (scan)
  );

  psws_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .scan (scan),
    .tail (tail)
  );

  assign m_tdata = {7'd0, status, ready_cnt, woken, switched, running};

endmodule
`default_nettype wire

// File: rtl/psws_checker.sv
`default_nettype none
module psws_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[4:0] <= 5'd16)
    else $error("running slot out of range");

  a_ignored: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[16] |-> !m_tdata[5] && m_tdata[10:6] == 5'd0)
    else $error("ignored event shows a switch or wake");

  a_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5] && m_tdata[4:0] == 5'd16 |-> m_tdata[15:11] == 5'd0)
    else $error("idle chosen with ready work waiting");

endmodule

bind priority_scheduler_with_sleep psws_checker u_psws_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;

  // Members run from the top bit down, so running_slot lands in the lowest bits.
  typedef struct packed {
    logic       status;
    logic [4:0] ready_count;
    logic [4:0] woken_count;
    logic       switched;
    logic [4:0] running_slot;
  } sched_res_t;

  priority_scheduler_with_sleep dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Shadow copy of the scheduler state.
  logic [7:0]            sh_slice_len;
  psws_pkg::slot_state_t sh_state [psws_pkg::NUM_SLOTS];
  logic [5:0]            sh_prio  [psws_pkg::NUM_SLOTS];
  logic [31:0]           sh_wake  [psws_pkg::NUM_SLOTS];
  logic [31:0]           sh_stamp [psws_pkg::NUM_SLOTS];
  logic [31:0]           sh_order;
  int unsigned           sh_cur;
  logic [7:0]            sh_slice_cnt;

  sched_res_t expected_results[$];
  int         err_count;
  int         cycle_count;
  int         stall_long;
  int         sent_count;
  logic [31:0] tick_now;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [31:0] take_stamp();
    logic [31:0] s;
    s = sh_order;
    sh_order = sh_order + 1;
    return s;
  endfunction

  function automatic int unsigned head_of_ready();
    int unsigned best;
    best = psws_pkg::NUM_SLOTS;
    for (int i = 0; i < psws_pkg::NUM_SLOTS; i++) begin
      if (sh_state[i] == psws_pkg::ST_READY) begin
        if (best == psws_pkg::NUM_SLOTS || sh_prio[i] > sh_prio[best] ||
            (sh_prio[i] == sh_prio[best] && sh_stamp[i] < sh_stamp[best]))
          best = i;
      end
    end
    return best;
  endfunction

  function automatic void make_ready(int unsigned s);
    sh_state[s] = psws_pkg::ST_READY;
    sh_stamp[s] = take_stamp();
  endfunction

  function automatic void pick_next();
    int unsigned h;
    h = head_of_ready();
    if (h != psws_pkg::NUM_SLOTS) sh_state[h] = psws_pkg::ST_RUNNING;
    sh_cur = h;
    sh_slice_cnt = 0;
  endfunction

  function automatic void give_up_cpu();
    if (sh_cur < psws_pkg::NUM_SLOTS) make_ready(sh_cur);
    pick_next();
  endfunction

  function automatic logic check_preempt();
    int unsigned h;
    h = head_of_ready();
    if (h != psws_pkg::NUM_SLOTS && sh_cur < psws_pkg::NUM_SLOTS &&
        sh_prio[sh_cur] < sh_prio[h]) begin
      give_up_cpu();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int wake_due(logic [31:0] now);
    int n;
    int unsigned best;
    n = 0;
    for (int r = 0; r < psws_pkg::NUM_SLOTS; r++) begin
      best = psws_pkg::NUM_SLOTS;
      for (int i = 0; i < psws_pkg::NUM_SLOTS; i++) begin
        if (sh_state[i] == psws_pkg::ST_SLEEPING && sh_wake[i] <= now) begin
          if (best == psws_pkg::NUM_SLOTS || sh_wake[i] < sh_wake[best] ||
              (sh_wake[i] == sh_wake[best] && sh_stamp[i] < sh_stamp[best]))
            best = i;
        end
      end
      if (best == psws_pkg::NUM_SLOTS) break;
      make_ready(best);
      n++;
    end
    return n;
  endfunction

  function automatic sched_res_t predict_event(psws_pkg::kind_t k, logic [3:0] slot,
                                               logic [5:0] prio, logic [31:0] tv);
    sched_res_t r;
    int nready;
    r = '0;
    case (k)
      psws_pkg::K_TICK: begin
        r.woken_count = 5'(wake_due(tv));
        if (sh_slice_cnt < 8'd255) sh_slice_cnt++;
        if (sh_slice_cnt >= sh_slice_len) begin
          give_up_cpu();
          r.switched = 1'b1;
        end
      end
      psws_pkg::K_CREATE: begin
        if (sh_state[slot] != psws_pkg::ST_FREE) r.status = 1'b1;
        else begin
          sh_prio[slot] = prio;
          make_ready(slot);
          r.switched = check_preempt();
        end
      end
      psws_pkg::K_UNBLOCK: begin
        if (sh_state[slot] != psws_pkg::ST_BLOCKED) r.status = 1'b1;
        else make_ready(slot);
      end
      psws_pkg::K_YIELD: begin
        give_up_cpu();
        r.switched = 1'b1;
      end
      default: begin
        if (sh_cur >= psws_pkg::NUM_SLOTS) r.status = 1'b1;
        else if (k == psws_pkg::K_SETPRIO) begin
          sh_prio[sh_cur] = prio;
          r.switched = check_preempt();
        end else begin
          if (k == psws_pkg::K_SLEEP) begin
            sh_wake[sh_cur] = tv;
            sh_stamp[sh_cur] = take_stamp();
            sh_state[sh_cur] = psws_pkg::ST_SLEEPING;
          end else if (k == psws_pkg::K_BLOCK) sh_state[sh_cur] = psws_pkg::ST_BLOCKED;
          else sh_state[sh_cur] = psws_pkg::ST_FREE;
          pick_next();
          r.switched = 1'b1;
        end
      end
    endcase
    nready = 0;
    for (int i = 0; i < psws_pkg::NUM_SLOTS; i++)
      if (sh_state[i] == psws_pkg::ST_READY) nready++;
    r.running_slot = 5'(sh_cur);
    r.ready_count = 5'(nready);
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 90);
    return $urandom_range(0, 3);
  endfunction

  // Valid stays high across a zero gap so that back-to-back transactions need no
  // second assignment in the same time step.
  task automatic send_event(psws_pkg::kind_t k, logic [3:0] slot, logic [5:0] prio,
                            logic [31:0] tv);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    expected_results.push_back(predict_event(k, slot, prio, tv));
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {6'd0, tv, prio, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_slice(logic [7:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sh_slice_len = v;
  endtask

  // Result side: random back-pressure, with a quiet stretch now and then.
  always @(posedge clk) begin
    sched_res_t got, want;
    if (rst) m_tready <= 1'b0;
    else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[16:0];
        if (expected_results.size() == 0) begin
          $error("unexpected result %h", got);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.running_slot !== want.running_slot) begin
            $error("running_slot exp %0d got %0d", want.running_slot, got.running_slot);
            err_count++;
          end
          if (got.switched !== want.switched) begin
            $error("switched exp %0d got %0d", want.switched, got.switched);
            err_count++;
          end
          if (got.woken_count !== want.woken_count) begin
            $error("woken_count exp %0d got %0d", want.woken_count, got.woken_count);
            err_count++;
          end
          if (got.ready_count !== want.ready_count) begin
            $error("ready_count exp %0d got %0d", want.ready_count, got.ready_count);
            err_count++;
          end
          if (got.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, got.status);
            err_count++;
          end
        end
      end
      if (stall_long > 0) begin
        stall_long <= stall_long - 1;
        m_tready <= 1'b0;
      end else if ((cycle_count / 3000) % 4 == 0) m_tready <= 1'b1;
      else if ($urandom_range(0, 99) == 0) begin
        stall_long <= $urandom_range(20, 120);
        m_tready <= 1'b0;
      end else m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic test_idle_cases();
    send_event(psws_pkg::K_SLEEP, 4'd0, 6'd0, 32'd5);
    send_event(psws_pkg::K_BLOCK, 4'd0, 6'd0, 32'd0);
    send_event(psws_pkg::K_SETPRIO, 4'd0, 6'd9, 32'd0);
    send_event(psws_pkg::K_EXIT, 4'd0, 6'd0, 32'd0);
    send_event(psws_pkg::K_YIELD, 4'd0, 6'd0, 32'd0);
    send_event(psws_pkg::K_UNBLOCK, 4'd3, 6'd0, 32'd0);
  endtask

  task automatic test_basic_ops();
    send_event(psws_pkg::K_CREATE, 4'd0, 6'd10, 32'd0);
    send_event(psws_pkg::K_CREATE, 4'd0, 6'd10, 32'd0);
    send_event(psws_pkg::K_TICK, 4'd0, 6'd0, 32'd1);
    send_event(psws_pkg::K_CREATE, 4'd15, 6'd63, 32'hFFFFFFFF);
    send_event(psws_pkg::K_CREATE, 4'd7, 6'd63, 32'd0);
    send_event(psws_pkg::K_SETPRIO, 4'd0, 6'd0, 32'd0);
    send_event(psws_pkg::K_SLEEP, 4'd0, 6'd0, 32'd0);
    send_event(psws_pkg::K_TICK, 4'd0, 6'd0, 32'd0);
    send_event(psws_pkg::K_BLOCK, 4'd0, 6'd0, 32'd0);
    send_event(psws_pkg::K_UNBLOCK, 4'd15, 6'd0, 32'd0);
    send_event(psws_pkg::K_SLEEP, 4'd0, 6'd0, 32'hFFFFFFFF);
    send_event(psws_pkg::K_YIELD, 4'd0, 6'd0, 32'd0);
    send_event(psws_pkg::K_EXIT, 4'd0, 6'd0, 32'd0);
    send_event(psws_pkg::K_TICK, 4'd0, 6'd0, 32'hFFFFFFFF);
    send_event(psws_pkg::K_TICK, 4'd0, 6'd0, 32'd2);
  endtask

  // Mostly well-formed traffic: ticks advance, threads are created, slept and woken.
  task automatic test_random_traffic(int n);
    psws_pkg::kind_t k;
    logic [3:0] slot;
    logic [31:0] tv;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      slot = 4'($urandom_range(0, 15));
      if (sel < 30) k = psws_pkg::K_TICK;
      else if (sel < 45) k = psws_pkg::K_CREATE;
      else if (sel < 55) k = psws_pkg::K_UNBLOCK;
      else if (sel < 67) k = psws_pkg::K_SLEEP;
      else if (sel < 75) k = psws_pkg::K_YIELD;
      else if (sel < 82) k = psws_pkg::K_BLOCK;
      else if (sel < 91) k = psws_pkg::K_SETPRIO;
      else k = psws_pkg::K_EXIT;
      if (k == psws_pkg::K_UNBLOCK && $urandom_range(0, 3) != 0) begin
        for (int j = 0; j < psws_pkg::NUM_SLOTS; j++)
          if (sh_state[j] == psws_pkg::ST_BLOCKED) slot = 4'(j);
      end
      if (k == psws_pkg::K_TICK) begin
        tick_now = tick_now + $urandom_range(0, 3);
        tv = ($urandom_range(0, 40) == 0) ? $urandom() : tick_now;
      end else if (k == psws_pkg::K_SLEEP) tv = tick_now + $urandom_range(0, 8);
      else tv = $urandom();
      send_event(k, slot, 6'($urandom_range(0, 63)), tv);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    err_count = 0;
    cycle_count = 0;
    stall_long = 0;
    sent_count = 0;
    tick_now = 0;
    sh_slice_len = psws_pkg::SLICE_RESET;
    sh_order = 0;
    sh_cur = psws_pkg::NUM_SLOTS;
    sh_slice_cnt = 0;
    for (int i = 0; i < psws_pkg::NUM_SLOTS; i++) begin
      sh_state[i] = psws_pkg::ST_FREE;
      sh_prio[i] = '0;
      sh_wake[i] = '0;
      sh_stamp[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_cases();
    test_basic_ops();
    write_slice(8'd1);
    test_random_traffic(200);
    write_slice(8'd255);
    test_random_traffic(200);
    write_slice(8'd0);
    test_random_traffic(100);
    write_slice(8'($urandom_range(2, 8)));
    test_random_traffic(350);
    drain();
    if (err_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/psws_pkg.sv
rtl/psws_cell.sv
rtl/psws_chain.sv
rtl/psws_ctrl.sv
rtl/priority_scheduler_with_sleep.sv
rtl/psws_checker.sv
tb/tb_top.sv
